[rtl/core/bhce_pkg.sv]
// Shared types, code tables and helper functions of the block Huffman coefficient encoder.
`timescale 1ns / 1ps

package bhce_pkg;

	localparam int COEF_W  = 12;
	localparam int BYTE_W  = 8;
	localparam int MAG_W   = 11;
	localparam int SIZE_W  = 4;
	localparam int ROM_W   = 17;
	localparam int CODE_W  = 16;
	localparam int LEN_W   = 5;
	localparam int ACC_W   = 56;
	localparam int TOT_W   = 6;
	localparam int CNT_W   = 3;
	localparam int PEND_W  = 7;
	localparam int RUN_W   = 6;
	localparam int ZRL_W   = 18;

	// One run-of-sixteen code, marker bit removed
	localparam logic [5:0] ZRL_CODE = 6'h33;
	localparam int         ZRL_LEN  = 6;

	// Code words carry a marker 1 just above the code bits
	localparam logic [ROM_W-1:0] DC_ROM [12] = '{
		17'h0001b, 17'h0000e, 17'h00004, 17'h00005, 17'h0000f, 17'h0000c,
		17'h00035, 17'h00069, 17'h001a0, 17'h001a1, 17'h001a2, 17'h001a3
	};

	localparam logic [ROM_W-1:0] AC_ROM [11][16] = '{
		'{17'h0000a, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0,
		  17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h0, 17'h00073},
		'{17'h0000c, 17'h0001e, 17'h0001b, 17'h00013, 17'h0003a, 17'h0002c, 17'h0007e, 17'h00071,
		  17'h0005a, 17'h00049, 17'h0004a, 17'h000ee, 17'h000e4, 17'h000b6, 17'h00097, 17'h001de},
		'{17'h00008, 17'h0003e, 17'h0007f, 17'h00070, 17'h000ed, 17'h00091, 17'h001df, 17'h001ab,
		  17'h00121, 17'h003b2, 17'h003b1, 17'h003b0, 17'h002dc, 17'h005bf, 17'h006a7, 17'h006a5},
		'{17'h00017, 17'h0006b, 17'h00096, 17'h001aa, 17'h002de, 17'h006a6, 17'h005be, 17'h00ecd,
		  17'h00b77, 17'h00d49, 17'h01204, 17'h03b31, 17'h01202, 17'h05bae, 17'h01a90, 17'h0240b},
		'{17'h00034, 17'h001a8, 17'h00767, 17'h00903, 17'h03b33, 17'h01a91, 17'h03b30, 17'h07665,
		  17'h0b749, 17'h05bb5, 17'h09007, 17'h16e89, 17'h16e82, 17'h16ead, 17'h16edb, 17'h0b747},
		'{17'h000e5, 17'h00482, 17'h01203, 17'h16eb0, 17'h09003, 17'h16eaa, 17'h09000, 17'h16ea6,
		  17'h16ea4, 17'h16ea5, 17'h16e8c, 17'h16e8d, 17'h16ece, 17'h16ecf, 17'h16eb4, 17'h16eb6},
		'{17'h00483, 17'h16eb7, 17'h16ec4, 17'h16ec5, 17'h0900e, 17'h0900f, 17'h16e9e, 17'h16ea0,
		  17'h16ea1, 17'h16e9a, 17'h16e9b, 17'h16e9c, 17'h16e9d, 17'h16e98, 17'h16e99, 17'h16ec0},
		'{17'h16ec1, 17'h16ec2, 17'h16ec3, 17'h16e95, 17'h16e96, 17'h16e97, 17'h16e90, 17'h12056,
		  17'h12057, 17'h12054, 17'h12055, 17'h12052, 17'h12053, 17'h09028, 17'h16e94, 17'h1d993},
		'{17'h16ebf, 17'h16ebc, 17'h16ebd, 17'h16ec7, 17'h16e87, 17'h16e80, 17'h16e81, 17'h16ecc,
		  17'h16ecd, 17'h16e85, 17'h16eca, 17'h16ecb, 17'h16ec8, 17'h16ec9, 17'h16ede, 17'h09005},
		'{17'h16edc, 17'h16edd, 17'h16ed8, 17'h16ed9, 17'h09006, 17'h16e8b, 17'h16ed1, 17'h16ed2,
		  17'h16ed3, 17'h16e83, 17'h16eac, 17'h16eda, 17'h16e88, 17'h16ed0, 17'h16e8a, 17'h09008},
		'{17'h09009, 17'h16eb2, 17'h09004, 17'h16eb3, 17'h0900a, 17'h0900b, 17'h16e84, 17'h16eb1,
		  17'h09002, 17'h16e86, 17'h16ec6, 17'h16eab, 17'h16ebe, 17'h1d992, 17'h1d990, 17'h16ea7}
	};

	// Encoded item handed from the encoder to the byte serialiser
	typedef struct packed {
		logic [ACC_W-1:0] data;
		logic [CNT_W-1:0] nbytes;
		logic             flush;
	} enc_item_t;

	// Look up a code word; sizes past the table read as no code
	function automatic logic [ROM_W-1:0] rom_word(logic is_dc, logic [SIZE_W-1:0] size,
			logic [3:0] run);
		logic [ROM_W-1:0] w;
		w = '0;
		if (is_dc) begin
			if (size <= SIZE_W'(11))
				w = DC_ROM[size];
		end else begin
			if (size <= SIZE_W'(10))
				w = AC_ROM[size][run];
		end
		return w;
	endfunction

	// Marker position, which is the code length
	function automatic logic [LEN_W-1:0] word_len(logic [ROM_W-1:0] w);
		logic [LEN_W-1:0] len;
		len = '0;
		for (int i = 0; i < ROM_W; i++) begin
			if (w[i])
				len = LEN_W'(i);
		end
		return len;
	endfunction

	// Number of significant bits of a magnitude
	function automatic logic [SIZE_W-1:0] mag_size(logic [MAG_W-1:0] m);
		logic [SIZE_W-1:0] n;
		n = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (m[i])
				n = SIZE_W'(i + 1);
		end
		return n;
	endfunction

	// Concatenation of up to three run-of-sixteen codes
	function automatic logic [ZRL_W-1:0] zrl_bits(logic [1:0] cnt);
		logic [ZRL_W-1:0] r;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < cnt)
				r = (r << ZRL_LEN) | ZRL_W'(ZRL_CODE);
		end
		return r;
	endfunction

endpackage

[rtl/core/bhce_if.sv]
// Channel interfaces: coefficient items in, packed code bytes out.
`timescale 1ns / 1ps

interface bhce_coef_if;
	logic                                valid;
	logic                                ready;
	logic signed [bhce_pkg::COEF_W-1:0]  coefficient;
	logic                                end_of_image;

	modport source(output valid, output coefficient, output end_of_image, input ready);
	modport sink(input valid, input coefficient, input end_of_image, output ready);
endinterface

interface bhce_byte_if;
	logic                        valid;
	logic                        ready;
	logic [bhce_pkg::BYTE_W-1:0] out_byte;
	logic                        last_of_run;
	logic                        final_byte;

	modport source(output valid, output out_byte, output last_of_run, output final_byte,
		input ready);
	modport sink(input valid, input out_byte, input last_of_run, input final_byte,
		output ready);
endinterface

[rtl/core/block_huffman_coefficient_encoder_unit.sv]
// Top level of the block Huffman coefficient encoder.
//
// Usage: coefficients arrive on the coef channel, one signed 12-bit value per item,
// in blocks of BLOCK_LEN; the first of each block is the DC value. Set end_of_image
// on the last coefficient of an image to flush the pending bits as a zero padded
// byte marked final_byte. Packed code bytes leave on the code channel, earliest
// bit in the MSB; last_of_run marks the last byte caused by one coefficient.
// Order: an item is taken into the input register, encoded in one pass and
// then loaded into the byte register, from which its first byte is shown.
// An item that completes no byte leaves nothing.
// Throughput: one item per cycle while items give at most one byte and the
// receiver keeps ready high; an item that gives more bytes (up to seven) holds
// the byte register until all have gone, since the output port hands over one
// byte per cycle while the receiver is ready.
// When the receiver stalls, the current byte holds and the input register keeps
// the next item, so ready drops only once both are full.
// Reset (arst_n low) empties both registers, restarts the block position and
// drops any pending bits.
`timescale 1ns / 1ps

module block_huffman_coefficient_encoder_unit #(
	parameter int BLOCK_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	bhce_coef_if.sink   coef,
	bhce_byte_if.source code
);

	logic                enc_valid;
	logic                enc_ready;
	bhce_pkg::enc_item_t enc_item;

	// Encode one coefficient per cycle unless the byte serialiser holds it back
	bhce_encoder #(
		.BLOCK_LEN(BLOCK_LEN)
	) u_encoder (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.enc_valid(enc_valid),
		.enc_ready(enc_ready),
		.enc_item (enc_item)
	);

	// Hand out the bytes of each item
	bhce_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.enc_valid(enc_valid),
		.enc_ready(enc_ready),
		.enc_item (enc_item),
		.code     (code)
	);

endmodule

[rtl/core/bhce_encoder.sv]
// Input register, block state and single-pass code builder.
`timescale 1ns / 1ps

module bhce_encoder #(
	parameter int BLOCK_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	bhce_coef_if.sink           coef,
	output logic                enc_valid,
	input  logic                enc_ready,
	output bhce_pkg::enc_item_t enc_item
);

	localparam int PW = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;
	localparam logic [PW-1:0] LAST_POS = PW'(BLOCK_LEN - 1);

	logic                                valid_s1;
	logic signed [bhce_pkg::COEF_W-1:0]  coef_s1;
	logic                                eoi_s1;

	logic [PW-1:0]                       pos_q;
	logic [PW-1:0]                       zrun_q;
	logic [bhce_pkg::PEND_W-1:0]         pend_q;
	logic [2:0]                          pcnt_q;

	logic                                advance;
	logic                                is_dc, is_zero, is_eob, is_ac, at_end;
	logic signed [bhce_pkg::COEF_W-1:0]  v_sat;
	logic [bhce_pkg::MAG_W-1:0]          mag, mbits, mmask;
	logic [bhce_pkg::SIZE_W-1:0]         size, sh_code;
	logic [bhce_pkg::RUN_W-1:0]          zr6;
	logic [1:0]                          zcnt;
	logic [bhce_pkg::ROM_W-1:0]          word;
	logic [bhce_pkg::LEN_W-1:0]          clen;
	logic [bhce_pkg::CODE_W-1:0]         cbits;
	logic [bhce_pkg::TOT_W-1:0]          sh_zrl, sh_pend, total;
	logic [bhce_pkg::ACC_W-1:0]          acc, left;
	logic [2:0]                          new_pc;
	logic                                flush;

	// Take a new item whenever the input register is empty or moves on
	assign coef.ready = !valid_s1 || advance;
	assign advance    = valid_s1 && (enc_item.nbytes == '0 || enc_ready);
	assign enc_valid  = valid_s1 && enc_item.nbytes != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coef.ready) begin
			valid_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (coef.valid && coef.ready) begin
			coef_s1 <= coef.coefficient;
			eoi_s1  <= coef.end_of_image;
		end
	end

	// Classify the coefficient
	always_comb begin
		is_dc   = pos_q == '0;
		is_zero = coef_s1 == '0;
		at_end  = pos_q == LAST_POS;
		is_eob  = !is_dc && is_zero && at_end;
		is_ac   = !is_dc && !is_zero;
	end

	// Saturate, then split into size and magnitude bits
	always_comb begin
		if (is_dc) begin
			v_sat = (coef_s1 == -12'sd2048) ? -12'sd2047 : coef_s1;
		end else if (coef_s1 > 12'sd1023) begin
			v_sat = 12'sd1023;
		end else if (coef_s1 < -12'sd1023) begin
			v_sat = -12'sd1023;
		end else begin
			v_sat = coef_s1;
		end
		mag   = bhce_pkg::MAG_W'(v_sat[bhce_pkg::COEF_W-1] ? -v_sat : v_sat);
		size  = bhce_pkg::mag_size(mag);
		mmask = bhce_pkg::MAG_W'((12'd1 << size) - 12'd1);
		mbits = (v_sat[bhce_pkg::COEF_W-1] ? ~mag : mag) & mmask;
	end

	// Pick the code word and lay out all segments right-aligned
	always_comb begin
		zr6     = bhce_pkg::RUN_W'(zrun_q);
		zcnt    = is_ac ? zr6[5:4] : 2'd0;
		word    = (is_dc || is_ac || is_eob)
			? bhce_pkg::rom_word(is_dc, size, is_ac ? zr6[3:0] : 4'd0) : '0;
		clen    = bhce_pkg::word_len(word);
		cbits   = bhce_pkg::CODE_W'(word & ~(bhce_pkg::ROM_W'(1) << clen));
		sh_code = (is_dc || is_ac) ? size : '0;
		sh_zrl  = bhce_pkg::TOT_W'(clen) + bhce_pkg::TOT_W'(sh_code);
		sh_pend = sh_zrl + bhce_pkg::TOT_W'(zcnt) * bhce_pkg::TOT_W'(bhce_pkg::ZRL_LEN);
		total   = sh_pend + bhce_pkg::TOT_W'(pcnt_q);
		acc     = bhce_pkg::ACC_W'(sh_code == '0 ? '0 : mbits)
			| (bhce_pkg::ACC_W'(cbits) << sh_code)
			| (bhce_pkg::ACC_W'(bhce_pkg::zrl_bits(zcnt)) << sh_zrl)
			| (bhce_pkg::ACC_W'(pend_q) << sh_pend);
		left    = acc << (bhce_pkg::TOT_W'(bhce_pkg::ACC_W) - total);
		new_pc  = total[2:0];
		flush   = eoi_s1 && new_pc != '0;
	end

	// Bytes leave left-aligned; a flush byte is the zero padded remainder
	always_comb begin
		enc_item.data   = left;
		enc_item.nbytes = total[bhce_pkg::TOT_W-1:3] + bhce_pkg::CNT_W'(flush);
		enc_item.flush  = flush;
	end

	// Advance block position, zero run and pending bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			zrun_q <= '0;
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (advance) begin
			if (eoi_s1) begin
				pos_q  <= '0;
				zrun_q <= '0;
				pend_q <= '0;
				pcnt_q <= '0;
			end else begin
				pos_q  <= at_end ? '0 : pos_q + PW'(1);
				zrun_q <= (at_end || !is_zero || is_dc) ? '0 : zrun_q + PW'(1);
				pend_q <= acc[bhce_pkg::PEND_W-1:0]
					& bhce_pkg::PEND_W'((8'd1 << new_pc) - 8'd1);
				pcnt_q <= new_pc;
			end
		end
	end

endmodule

[rtl/core/bhce_serializer.sv]
// Result register that hands out the bytes of one encoded item, one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module bhce_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                enc_valid,
	output logic                enc_ready,
	input  bhce_pkg::enc_item_t enc_item,
	bhce_byte_if.source         code
);

	logic [bhce_pkg::ACC_W-1:0] data_q;
	logic [bhce_pkg::CNT_W-1:0] left_q;
	logic                       flush_q;
	logic                       take;
	logic                       load;

	// Free once empty or while the last byte goes out
	assign take      = code.valid && code.ready;
	assign enc_ready = left_q == '0 || (left_q == bhce_pkg::CNT_W'(1) && code.ready);
	assign load      = enc_valid && enc_ready;

	assign code.valid       = left_q != '0;
	assign code.out_byte    = data_q[bhce_pkg::ACC_W-1 -: bhce_pkg::BYTE_W];
	assign code.last_of_run = left_q == bhce_pkg::CNT_W'(1);
	assign code.final_byte  = left_q == bhce_pkg::CNT_W'(1) && flush_q;

	// Count the bytes still to go
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= enc_item.nbytes;
		end else if (take) begin
			left_q <= left_q - bhce_pkg::CNT_W'(1);
		end
	end

	// Hold the bytes; shift the next one up after each handover
	always_ff @(posedge clk) begin
		if (load) begin
			data_q  <= enc_item.data;
			flush_q <= enc_item.flush;
		end else if (take) begin
			data_q  <= data_q << bhce_pkg::BYTE_W;
		end
	end

endmodule
